>>> src/bdls_pkg.sv
// ----------------------------------------------------------------------------
// bdls_pkg
// Shared types and constants for the button debounce and LED pattern
// sequencer: mode codes, register indexes, reset values and the structs
// that pass between the lanes, the sequencer and the top level.
// ----------------------------------------------------------------------------
package bdls_pkg;

  // Field widths.
  localparam int unsigned LEVELS_W  = 4;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned DEB_W     = 5;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned SINCE_W   = 32;
  localparam int unsigned PHASE_W   = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // LED mode codes.
  localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PROCESSING = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUCCESS    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FAILURE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WAITING    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PRESSED    = 3'd5;

  // Command bytes.
  localparam logic [CMD_W-1:0] CMD_MODE_FIRST = 8'd1;
  localparam logic [CMD_W-1:0] CMD_MODE_LAST  = 8'd6;
  localparam logic [CMD_W-1:0] CMD_REBOOT     = 8'h07;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS    = 2'd3;

  // Configuration reset values.
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 5'd20;
  localparam logic [HOLD_W-1:0] SUCCESS_RST  = 16'd600;
  localparam logic [HOLD_W-1:0] FAILURE_RST  = 16'd800;
  localparam logic [HOLD_W-1:0] PRESS_RST    = 16'd120;

  // Blink and flash timing in ticks.
  localparam logic [PHASE_W-1:0] PHASE_LAST   = 8'd249;  // 250 ticks per half period
  localparam logic [SINCE_W-1:0] FLASH1_END   = 32'd100;
  localparam logic [SINCE_W-1:0] FLASH2_START = 32'd200;
  localparam logic [SINCE_W-1:0] FLASH2_END   = 32'd300;

  // One accepted tick as seen by the sequencer.
  typedef struct packed {
    logic             accept;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_byte;
    logic             any_press;
  } tick_t;

  // Sequencer result for one tick.
  typedef struct packed {
    logic              lit;
    logic              reboot;
    logic [MODE_W-1:0] mode;
  } seq_res_t;

  // Timed-mode limits.
  typedef struct packed {
    logic [HOLD_W-1:0] success_hold;
    logic [HOLD_W-1:0] failure_end;
    logic [HOLD_W-1:0] press_flash;
  } hold_cfg_t;

endpackage

>>> src/bdls_lane.sv
// ----------------------------------------------------------------------------
// bdls_lane
// Debounce lane for one button: remembers the last accepted level and runs
// the lockout counter that blocks further changes after one is accepted.
// ----------------------------------------------------------------------------
module bdls_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          level,
  input  logic [bdls_pkg::DEB_W-1:0]    debounce,
  output logic                          pressed
);

  logic [bdls_pkg::DEB_W-1:0] lock_r;
  logic [bdls_pkg::DEB_W-1:0] lock_nxt;
  logic                       last_r;
  logic                       last_nxt;
  logic [bdls_pkg::DEB_W-1:0] lock_dec;

  always_comb begin
    lock_dec = (lock_r != '0) ? lock_r - 1'b1 : '0;
    lock_nxt = lock_dec;
    last_nxt = last_r;
    pressed  = 1'b0;
    // A level change counts only once the lockout has run out.
    if (lock_dec == '0 && level != last_r) begin
      last_nxt = level;
      lock_nxt = debounce;
      pressed  = ~level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= '0;
      last_r <= 1'b1;
    end else if (accept) begin
      lock_r <= lock_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

>>> src/bdls_seq.sv
// ----------------------------------------------------------------------------
// bdls_seq
// LED mode sequencer: applies commands and merged button presses, keeps the
// elapsed-time counter with its 250-tick blink phase, and computes the LED.
// ----------------------------------------------------------------------------
module bdls_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdls_pkg::tick_t       tick,
  input  bdls_pkg::hold_cfg_t   hold,
  output bdls_pkg::seq_res_t    res
);

  logic [bdls_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [bdls_pkg::SINCE_W-1:0] since_r, since_nxt;
  logic [bdls_pkg::PHASE_W-1:0] ph_cnt_r, ph_cnt_nxt;
  logic                         ph_bit_r, ph_bit_nxt;

  logic [bdls_pkg::SINCE_W:0]   since_inc;
  logic [bdls_pkg::SINCE_W-1:0] since_b;
  logic [bdls_pkg::PHASE_W-1:0] ph_cnt_a, ph_cnt_b;
  logic                         ph_bit_a, ph_bit_b;
  logic [bdls_pkg::MODE_W-1:0]  mode_b;
  logic                         restart;
  logic                         reboot;
  logic                         lit;
  logic                         expire;

  always_comb begin
    // Elapsed time advances; the phase counter tracks since / 250 and
    // restarts with it when the 32-bit count wraps.
    since_inc = {1'b0, since_r} + 33'd1;
    if (since_inc[bdls_pkg::SINCE_W]) begin
      ph_cnt_a = '0;
      ph_bit_a = 1'b0;
    end else if (ph_cnt_r == bdls_pkg::PHASE_LAST) begin
      ph_cnt_a = '0;
      ph_bit_a = ~ph_bit_r;
    end else begin
      ph_cnt_a = ph_cnt_r + 1'b1;
      ph_bit_a = ph_bit_r;
    end

    mode_b  = mode_r;
    restart = 1'b0;
    reboot  = 1'b0;
    if (tick.cmd_valid) begin
      if (tick.cmd_byte inside {[bdls_pkg::CMD_MODE_FIRST:bdls_pkg::CMD_MODE_LAST]}) begin
        mode_b  = bdls_pkg::MODE_W'(tick.cmd_byte - 8'd1);
        restart = 1'b1;
      end else if (tick.cmd_byte == bdls_pkg::CMD_REBOOT) begin
        reboot = 1'b1;
      end
    end
    // Buttons are handled after the command, so a press wins.
    if (tick.any_press) begin
      mode_b  = bdls_pkg::MODE_PRESSED;
      restart = 1'b1;
    end

    since_b  = restart ? '0 : since_inc[bdls_pkg::SINCE_W-1:0];
    ph_cnt_b = restart ? '0 : ph_cnt_a;
    ph_bit_b = restart ? 1'b0 : ph_bit_a;

    lit    = 1'b0;
    expire = 1'b0;
    case (mode_b)
      bdls_pkg::MODE_PROCESSING: lit = ph_bit_b;
      bdls_pkg::MODE_SUCCESS: begin
        lit    = 1'b1;
        expire = since_b > bdls_pkg::SINCE_W'(hold.success_hold);
      end
      bdls_pkg::MODE_FAILURE: begin
        lit    = (since_b < bdls_pkg::FLASH1_END) ||
                 (since_b > bdls_pkg::FLASH2_START && since_b < bdls_pkg::FLASH2_END);
        expire = since_b > bdls_pkg::SINCE_W'(hold.failure_end);
      end
      bdls_pkg::MODE_WAITING: lit = 1'b1;
      bdls_pkg::MODE_PRESSED: begin
        lit    = 1'b1;
        expire = since_b > bdls_pkg::SINCE_W'(hold.press_flash);
      end
      default: lit = 1'b0;
    endcase

    mode_nxt   = expire ? bdls_pkg::MODE_IDLE : mode_b;
    since_nxt  = expire ? '0 : since_b;
    ph_cnt_nxt = expire ? '0 : ph_cnt_b;
    ph_bit_nxt = expire ? 1'b0 : ph_bit_b;

    res.lit    = lit | reboot;
    res.reboot = reboot;
    res.mode   = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bdls_pkg::MODE_IDLE;
      since_r  <= '0;
      ph_cnt_r <= '0;
      ph_bit_r <= 1'b0;
    end else if (tick.accept) begin
      mode_r   <= mode_nxt;
      since_r  <= since_nxt;
      ph_cnt_r <= ph_cnt_nxt;
      ph_bit_r <= ph_bit_nxt;
    end
  end

endmodule

>>> src/button_debounce_led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// button_debounce_led_pattern_sequencer
// Each transfer on the input channel is one millisecond tick carrying four
// active-low button levels and an optional command byte; each tick produces
// exactly one result transfer with the LED drive, the buttons whose press
// was accepted, a reboot flag and the LED mode after the tick. The
// per-button debounce lanes and the mode sequencer update their state as
// the tick is accepted, and the result goes into an output register, so a
// new tick is taken every clock while the result side keeps up, and the
// input is stalled only while a finished result is held by a stalled
// output. Configuration writes take effect at the clock edge of the write
// and must be made while no tick is in flight.
// ----------------------------------------------------------------------------
module button_debounce_led_pattern_sequencer #(
  parameter int unsigned BUTTONS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Tick input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bdls_pkg::LEVELS_W-1:0]      in_button_levels,
  input  logic                               in_cmd_valid,
  input  logic [bdls_pkg::CMD_W-1:0]         in_cmd_byte,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_led1_on,
  output logic                               out_led2_on,
  output logic [bdls_pkg::LEVELS_W-1:0]      out_pressed_mask,
  output logic                               out_reboot_request,
  output logic [bdls_pkg::MODE_W-1:0]        out_led_mode_now,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [bdls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdls_pkg::CFG_W-1:0]         cfg_wdata
);

  // Configuration registers.
  logic [bdls_pkg::DEB_W-1:0]  debounce_r;
  logic [bdls_pkg::HOLD_W-1:0] success_r;
  logic [bdls_pkg::HOLD_W-1:0] failure_r;
  logic [bdls_pkg::HOLD_W-1:0] press_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bdls_pkg::DEBOUNCE_RST;
      success_r  <= bdls_pkg::SUCCESS_RST;
      failure_r  <= bdls_pkg::FAILURE_RST;
      press_r    <= bdls_pkg::PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdls_pkg::CFG_DEBOUNCE: debounce_r <= cfg_wdata[bdls_pkg::DEB_W-1:0];
        bdls_pkg::CFG_SUCCESS:  success_r  <= cfg_wdata[bdls_pkg::HOLD_W-1:0];
        bdls_pkg::CFG_FAILURE:  failure_r  <= cfg_wdata[bdls_pkg::HOLD_W-1:0];
        bdls_pkg::CFG_PRESS:    press_r    <= cfg_wdata[bdls_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // A tick is taken unless a finished result is waiting on a stalled output.
  logic out_valid_r;
  logic out_valid_nxt;
  logic accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // One debounce lane per button. Buttons past the input field read as
  // released, so their lanes never see a change.
  logic [BUTTONS-1:0] press_vec;

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    logic level;
    if (i < bdls_pkg::LEVELS_W) begin : g_in
      assign level = in_button_levels[i];
    end else begin : g_off
      assign level = 1'b1;
    end
    bdls_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (accept),
      .level    (level),
      .debounce (debounce_r),
      .pressed  (press_vec[i])
    );
  end

  // Merge the lanes: one press bit per reported button, and any press at all
  // for the mode sequencer.
  logic [bdls_pkg::LEVELS_W-1:0] mask;

  for (genvar j = 0; j < bdls_pkg::LEVELS_W; j++) begin : g_mask
    if (j < BUTTONS) begin : g_on
      assign mask[j] = press_vec[j];
    end else begin : g_none
      assign mask[j] = 1'b0;
    end
  end

  bdls_pkg::tick_t     tick;
  bdls_pkg::hold_cfg_t hold;
  bdls_pkg::seq_res_t  res;

  always_comb begin
    tick.accept         = accept;
    tick.cmd_valid      = in_cmd_valid;
    tick.cmd_byte       = in_cmd_byte;
    tick.any_press      = |press_vec;
    hold.success_hold   = success_r;
    hold.failure_end    = failure_r;
    hold.press_flash    = press_r;
  end

  bdls_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .hold  (hold),
    .res   (res)
  );

  // Output register.
  logic                          lit_r;
  logic [bdls_pkg::LEVELS_W-1:0] mask_r;
  logic                          reboot_r;
  logic [bdls_pkg::MODE_W-1:0]   mode_r;

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lit_r    <= res.lit;
      mask_r   <= mask;
      reboot_r <= res.reboot;
      mode_r   <= res.mode;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_led1_on        = lit_r;
  assign out_led2_on        = lit_r;
  assign out_pressed_mask   = mask_r;
  assign out_reboot_request = reboot_r;
  assign out_led_mode_now   = mode_r;

`ifndef SYNTHESIS
  // A reboot request always forces the LEDs on.
  a_reboot_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reboot_request) |-> out_led1_on)
    else $error("reboot request without LEDs lit");

  // An accepted press always leaves the block in button-pressed mode.
  a_press_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pressed_mask != '0) |-> (out_led_mode_now == bdls_pkg::MODE_PRESSED))
    else $error("press reported outside pressed mode");

  // Every accepted tick shows up as a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no result");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce and LED pattern sequencer.
// Ticks go in with random gaps and the results come out under random stalls.
// A behavioral copy of the sequencer runs beside the block, and every result
// transfer is compared field by field with the tick it belongs to.
// ----------------------------------------------------------------------------
module tb_top;

  // LED timing of the processing blink and the failure double flash.
  localparam int unsigned BLINK_TICKS  = 250;
  localparam int unsigned FAIL_ON1_END = 100;
  localparam int unsigned FAIL_ON2_LO  = 200;
  localparam int unsigned FAIL_ON2_HI  = 300;

  // Command bytes that the block must ignore.
  localparam logic [bdls_pkg::CMD_W-1:0] CMD_NONE          = 8'd0;
  localparam logic [bdls_pkg::CMD_W-1:0] CMD_IGNORED_FIRST = 8'd8;
  localparam logic [bdls_pkg::CMD_W-1:0] CMD_IGNORED_LAST  = 8'd255;

  localparam int unsigned GAP_PCT       = 32;   // chance of a gap or stall per cycle
  localparam int unsigned HOLD_CYCLES   = 60;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;    // quiet cycles after the last result
  localparam int unsigned QUIET_LIMIT   = 2000; // cycles with no transfer before giving up
  localparam int unsigned MAX_PRINTS    = 40;

  // What one tick is expected to show; both LEDs carry the same drive.
  typedef struct packed {
    logic                          lit;
    logic [bdls_pkg::LEVELS_W-1:0] pressed;
    logic                          reboot;
    logic [bdls_pkg::MODE_W-1:0]   mode;
  } tick_result_t;

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic [bdls_pkg::LEVELS_W-1:0]  in_button_levels = '1;
  logic                           in_cmd_valid     = 1'b0;
  logic [bdls_pkg::CMD_W-1:0]     in_cmd_byte      = '0;
  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic                           out_led1_on;
  logic                           out_led2_on;
  logic [bdls_pkg::LEVELS_W-1:0]  out_pressed_mask;
  logic                           out_reboot_request;
  logic [bdls_pkg::MODE_W-1:0]    out_led_mode_now;
  logic                           cfg_we           = 1'b0;
  logic [bdls_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
  logic [bdls_pkg::CFG_W-1:0]     cfg_wdata        = '0;

  button_debounce_led_pattern_sequencer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_button_levels   (in_button_levels),
    .in_cmd_valid       (in_cmd_valid),
    .in_cmd_byte        (in_cmd_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_led1_on        (out_led1_on),
    .out_led2_on        (out_led2_on),
    .out_pressed_mask   (out_pressed_mask),
    .out_reboot_request (out_reboot_request),
    .out_led_mode_now   (out_led_mode_now),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the sequencer state and of its timing registers.
  logic [bdls_pkg::MODE_W-1:0]   seq_mode;
  logic [bdls_pkg::SINCE_W-1:0]  seq_since;
  logic [bdls_pkg::LEVELS_W-1:0] seq_levels;
  logic [bdls_pkg::DEB_W-1:0]    seq_lockout [bdls_pkg::LEVELS_W];
  logic [bdls_pkg::DEB_W-1:0]    lim_debounce;
  logic [bdls_pkg::HOLD_W-1:0]   lim_success;
  logic [bdls_pkg::HOLD_W-1:0]   lim_failure;
  logic [bdls_pkg::HOLD_W-1:0]   lim_press;

  tick_result_t led_results_q [$];  // one expected result per accepted tick

  bit          calm         = 1'b0; // no gaps and no random stalls while set
  bit          hold_request = 1'b0; // asks the receiver for one long hold-off
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ticks_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  logic [bdls_pkg::LEVELS_W-1:0] held_levels = '1;  // button levels the stimulus is holding

  function automatic logic [bdls_pkg::CMD_W-1:0] mode_cmd(
      input logic [bdls_pkg::MODE_W-1:0] m);
    return bdls_pkg::CMD_MODE_FIRST + bdls_pkg::CMD_W'(m);
  endfunction

  task automatic reset_shadow();
    seq_mode     = bdls_pkg::MODE_IDLE;
    seq_since    = '0;
    seq_levels   = '1;
    lim_debounce = bdls_pkg::DEBOUNCE_RST;
    lim_success  = bdls_pkg::SUCCESS_RST;
    lim_failure  = bdls_pkg::FAILURE_RST;
    lim_press    = bdls_pkg::PRESS_RST;
    for (int i = 0; i < bdls_pkg::LEVELS_W; i++) seq_lockout[i] = '0;
  endtask

  // Advances the shadow by one tick and returns what the block must report.
  // The order matters: time and lockouts first, then the command, then the
  // buttons (so a press in the same tick as a command wins), then the LEDs.
  function automatic tick_result_t sequence_tick(
      input logic [bdls_pkg::LEVELS_W-1:0] levels,
      input logic cmd_valid,
      input logic [bdls_pkg::CMD_W-1:0] cmd);
    tick_result_t r;
    r = '0;
    seq_since = seq_since + 1'b1;
    for (int i = 0; i < bdls_pkg::LEVELS_W; i++) begin
      if (seq_lockout[i] != '0) seq_lockout[i] = seq_lockout[i] - 1'b1;
    end
    if (cmd_valid) begin
      if (cmd >= bdls_pkg::CMD_MODE_FIRST && cmd <= bdls_pkg::CMD_MODE_LAST) begin
        seq_mode  = bdls_pkg::MODE_W'(cmd - bdls_pkg::CMD_MODE_FIRST);
        seq_since = '0;
      end else if (cmd == bdls_pkg::CMD_REBOOT) begin
        r.reboot = 1'b1;
      end
    end
    for (int i = 0; i < bdls_pkg::LEVELS_W; i++) begin
      if (seq_lockout[i] == '0 && levels[i] != seq_levels[i]) begin
        seq_levels[i]  = levels[i];
        seq_lockout[i] = lim_debounce;
        if (!levels[i]) begin
          r.pressed[i] = 1'b1;
          seq_mode     = bdls_pkg::MODE_PRESSED;
          seq_since    = '0;
        end
      end
    end
    case (seq_mode)
      bdls_pkg::MODE_PROCESSING: begin
        r.lit = ((seq_since / BLINK_TICKS) % 2) == 1;
      end
      bdls_pkg::MODE_SUCCESS: begin
        r.lit = 1'b1;
        if (seq_since > lim_success) begin
          seq_mode  = bdls_pkg::MODE_IDLE;
          seq_since = '0;
        end
      end
      bdls_pkg::MODE_FAILURE: begin
        r.lit = (seq_since < FAIL_ON1_END) ||
                (seq_since > FAIL_ON2_LO && seq_since < FAIL_ON2_HI);
        if (seq_since > lim_failure) begin
          seq_mode  = bdls_pkg::MODE_IDLE;
          seq_since = '0;
        end
      end
      bdls_pkg::MODE_WAITING: begin
        r.lit = 1'b1;
      end
      bdls_pkg::MODE_PRESSED: begin
        r.lit = 1'b1;
        if (seq_since > lim_press) begin
          seq_mode  = bdls_pkg::MODE_IDLE;
          seq_since = '0;
        end
      end
      default: begin
        r.lit = 1'b0;
      end
    endcase
    if (r.reboot) r.lit = 1'b1;
    r.mode = seq_mode;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at result %0d: %s", results_checked, msg);
    mismatch_count++;
  endtask

  // Offers one tick, with random gaps in front of it unless the bench is in a
  // calm stretch, and holds the payload steady until the transfer happens.
  // Returns in the time step of the transfer, so the caller may drive the
  // next tick straight away without touching in_valid twice in one step.
  task automatic send_tick(input logic [bdls_pkg::LEVELS_W-1:0] levels,
                           input logic cmd_valid,
                           input logic [bdls_pkg::CMD_W-1:0] cmd);
    while (!calm && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_button_levels <= levels;
    in_cmd_valid     <= cmd_valid;
    in_cmd_byte      <= cmd;
    do @(posedge clk); while (in_stall !== 1'b0);
    led_results_q.push_back(sequence_tick(levels, cmd_valid, cmd));
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every expected result has arrived,
  // then lets the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (led_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four timing registers while the block is idle. Debounce takes
  // a full data word so that bits above its width are seen to be dropped.
  task automatic set_limits(input logic [bdls_pkg::CFG_W-1:0] debounce,
                            input logic [bdls_pkg::HOLD_W-1:0] success,
                            input logic [bdls_pkg::HOLD_W-1:0] failure,
                            input logic [bdls_pkg::HOLD_W-1:0] press);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= bdls_pkg::CFG_DEBOUNCE;
    cfg_wdata <= debounce;
    @(posedge clk);
    cfg_index <= bdls_pkg::CFG_SUCCESS;
    cfg_wdata <= success;
    @(posedge clk);
    cfg_index <= bdls_pkg::CFG_FAILURE;
    cfg_wdata <= failure;
    @(posedge clk);
    cfg_index <= bdls_pkg::CFG_PRESS;
    cfg_wdata <= press;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_debounce = debounce[bdls_pkg::DEB_W-1:0];
    lim_success  = success;
    lim_failure  = failure;
    lim_press    = press;
  endtask

  // Ticks that keep the current mode: the buttons stay put and the only
  // commands are reboot requests and bytes that must be ignored.
  task automatic quiet_ticks(input int unsigned count);
    logic                       cv;
    logic [bdls_pkg::CMD_W-1:0] cb;
    repeat (count) begin
      cv = $urandom_range(99) < 10;
      cb = bdls_pkg::CMD_W'($urandom_range(255));
      if (cv) begin
        case ($urandom_range(4))
          0, 1:    cb = bdls_pkg::CMD_REBOOT;
          2:       cb = CMD_NONE;
          default: cb = bdls_pkg::CMD_W'($urandom_range(CMD_IGNORED_LAST, CMD_IGNORED_FIRST));
        endcase
      end
      send_tick(held_levels, cv, cb);
    end
  endtask

  // Button activity with commands mixed in. A toggle is usually a single
  // button; now and then several flip at once, which looks like bounce.
  task automatic random_ticks(input int unsigned count, input int unsigned toggle_pct,
                              input int unsigned cmd_pct);
    logic                       cv;
    logic [bdls_pkg::CMD_W-1:0] cb;
    int unsigned                pick;
    repeat (count) begin
      if ($urandom_range(99) < toggle_pct) begin
        if ($urandom_range(3) == 0) begin
          held_levels ^= bdls_pkg::LEVELS_W'($urandom_range(15));
        end else begin
          held_levels[$urandom_range(bdls_pkg::LEVELS_W - 1)] ^= 1'b1;
        end
      end
      cv   = $urandom_range(99) < cmd_pct;
      pick = $urandom_range(99);
      cb   = bdls_pkg::CMD_W'($urandom_range(255));
      if (cv && pick < 50) begin
        cb = bdls_pkg::CMD_W'($urandom_range(bdls_pkg::CMD_MODE_LAST,
                                             bdls_pkg::CMD_MODE_FIRST));
      end else if (cv && pick < 65) begin
        cb = bdls_pkg::CMD_REBOOT;
      end
      send_tick(held_levels, cv, cb);
    end
  endtask

  // Reset values of the registers, every command byte class, and a press
  // followed by a release that falls into the lockout.
  task automatic test_reset_defaults();
    held_levels = '1;
    send_tick(held_levels, 1'b0, CMD_NONE);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_PROCESSING));
    send_tick(held_levels, 1'b1, bdls_pkg::CMD_REBOOT);  // mode kept, LEDs forced on
    send_tick(held_levels, 1'b1, CMD_NONE);
    send_tick(held_levels, 1'b1, CMD_IGNORED_LAST);
    send_tick(held_levels, 1'b1, CMD_IGNORED_FIRST);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_SUCCESS));
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_FAILURE));
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_WAITING));
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_PRESSED));
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_IDLE));
    held_levels = 4'b1110;
    send_tick(held_levels, 1'b0, CMD_NONE);
    held_levels = '1;                          // release lands inside the lockout
    send_tick(held_levels, 1'b0, CMD_NONE);
    held_levels = '0;                          // only the unlocked buttons count
    send_tick(held_levels, 1'b0, CMD_IGNORED_LAST);
  endtask

  // With no lockout every level change is taken on the tick it appears, and
  // a press in the same tick as a command overrides the command's mode.
  task automatic test_zero_debounce();
    set_limits('0, bdls_pkg::SUCCESS_RST, bdls_pkg::FAILURE_RST, bdls_pkg::PRESS_RST);
    held_levels = '1;
    send_tick(held_levels, 1'b0, CMD_NONE);
    held_levels = 4'b1011;
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_SUCCESS));
    held_levels = '1;
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_WAITING));
    held_levels = 4'b0111;
    send_tick(held_levels, 1'b1, bdls_pkg::CMD_REBOOT);
    held_levels = 4'b0101;
    send_tick(held_levels, 1'b0, CMD_NONE);
    held_levels = 4'b0111;
    send_tick(held_levels, 1'b0, CMD_NONE);
    held_levels = 4'b0101;
    send_tick(held_levels, 1'b0, CMD_NONE);
    held_levels = '1;
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_IDLE));
  endtask

  // Long runs in each timed mode so that the blink edge, both failure
  // flashes and every fall back to idle are reached, then zero hold times.
  task automatic test_timed_modes();
    set_limits(16'd31, 16'd40, 16'd310, 16'd10);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_PROCESSING));
    quiet_ticks(265);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_SUCCESS));
    quiet_ticks(45);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_FAILURE));
    quiet_ticks(315);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_WAITING));
    quiet_ticks(10);
    held_levels[2] = 1'b0;
    send_tick(held_levels, 1'b0, CMD_NONE);
    quiet_ticks(15);
    held_levels = '1;
    send_tick(held_levels, 1'b0, CMD_NONE);
    set_limits(16'd5, '0, '0, '0);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_SUCCESS));
    quiet_ticks(3);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_FAILURE));
    quiet_ticks(3);
    send_tick(held_levels, 1'b1, mode_cmd(bdls_pkg::MODE_PRESSED));
    quiet_ticks(3);
  endtask

  // Shortest nonzero lockout with hold times that never run out.
  task automatic test_fast_bounce();
    set_limits(16'd1, '1, '1, '1);
    random_ticks(150, 35, 8);
  endtask

  // A stretch with no gaps and no stalls at all, every hold time at zero.
  task automatic test_back_to_back();
    set_limits('0, '0, '0, '0);
    calm = 1'b1;
    random_ticks(150, 20, 10);
    drain_results();
    calm = 1'b0;
  endtask

  // Mid-range timing; the debounce word has a bit set above the register.
  task automatic test_mixed();
    set_limits(16'h0047, 16'd25, 16'd120, 16'd15);
    random_ticks(180, 10, 6);
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input while ticks keep coming; then the sender waits for a full drain.
  task automatic test_backpressure();
    set_limits(bdls_pkg::CFG_W'(bdls_pkg::DEBOUNCE_RST), bdls_pkg::SUCCESS_RST,
               bdls_pkg::FAILURE_RST, bdls_pkg::PRESS_RST);
    calm         = 1'b1;
    hold_request = 1'b1;
    random_ticks(40, 10, 5);
    drain_results();
    calm = 1'b0;
  endtask

  // Longest lockout with slow button activity, so timed modes run out often.
  task automatic test_slow_buttons();
    set_limits(16'd31, 16'd300, 16'd350, 16'd60);
    random_ticks(200, 4, 2);
  endtask

  // Result side: checks each result transfer against the oldest expectation
  // and decides the stall for the next cycle. A hold-off request turns into
  // a counted run of stalled cycles here.
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (led_results_q.size() == 0) begin
        flag_mismatch("result transfer with no tick waiting for it");
      end else begin
        want = led_results_q.pop_front();
        if (out_led1_on !== want.lit)
          flag_mismatch($sformatf("led1_on %b, expected %b", out_led1_on, want.lit));
        if (out_led2_on !== want.lit)
          flag_mismatch($sformatf("led2_on %b, expected %b", out_led2_on, want.lit));
        if (out_pressed_mask !== want.pressed)
          flag_mismatch($sformatf("pressed_mask %b, expected %b", out_pressed_mask,
                                  want.pressed));
        if (out_reboot_request !== want.reboot)
          flag_mismatch($sformatf("reboot_request %b, expected %b", out_reboot_request,
                                  want.reboot));
        if (out_led_mode_now !== want.mode)
          flag_mismatch($sformatf("led_mode_now %0d, expected %0d", out_led_mode_now,
                                  want.mode));
        results_checked++;
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < GAP_PCT);
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_debounce();
    test_timed_modes();
    test_fast_bounce();
    test_back_to_back();
    test_mixed();
    test_backpressure();
    test_slow_buttons();
    drain_results();
    $display("Sent %0d ticks and checked %0d results over eight timing setups,", ticks_sent,
             results_checked);
    $display("including every LED mode, lockout lengths 0 to 31 and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
